[sv/u8s_pkg.sv]
// Shared types and constants for the UTF-8 stream sanitizer.
// Used by u8s_step, u8s_emit and the top level; depends on nothing.
`timescale 1ns / 1ps

package u8s_pkg;

    typedef logic [7:0] byte_t;

    // Replacement for any invalid byte.
    localparam byte_t BLANK = 8'h20;

    // Bytes of one multi-byte sequence that can be held back.
    localparam int HOLD_DEPTH = 4;

    // Most results that one input byte can release.
    localparam int MAX_RESULTS = 5;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int POS_W = $clog2(HOLD_DEPTH + 1);

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [POS_W-1:0] pos_t;

    // Results released by one input byte, handed from the step logic
    // to the output buffer.
    typedef struct packed {
        cnt_t                          count;
        logic                          eob;
        logic [MAX_RESULTS-1:0][7:0]   bytes;
    } step_result_t;

endpackage

[sv/u8s_step.sv]
// Per-byte sanitizing logic and the held-sequence state registers.
// Depends on u8s_pkg.
`timescale 1ns / 1ps

module u8s_step
    import u8s_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   data_byte,
    input  logic         end_of_buffer,
    input  logic         accept,
    output step_result_t result
);

    byte_t held_reg [HOLD_DEPTH];
    byte_t held_next [HOLD_DEPTH];
    pos_t  pos_reg;
    pos_t  pos_next;
    pos_t  len_reg;
    pos_t  len_next;

    byte_t b;
    logic  cont;
    logic  done;
    cnt_t  pre_n;
    logic  pre_blank;
    pos_t  pos_p;
    pos_t  len_p;
    logic  mid_n;
    byte_t mid_byte;
    pos_t  pos_m;
    pos_t  len_m;
    cnt_t  post_n;
    logic  post_blank;
    cnt_t  pre_mid_n;

    // Settle the held sequence, handle the new byte, then close the buffer.
    always_comb
    begin
        b    = (data_byte == 8'h00) ? BLANK : data_byte;
        cont = (b[7:6] == 2'b10);

        // Release of bytes held from earlier transfers.
        pre_n     = '0;
        pre_blank = 1'b1;
        done      = 1'b0;
        pos_p     = pos_reg;
        len_p     = len_reg;
        if (pos_reg != '0)
        begin
            if (len_reg > 3'd1)
            begin
                if (!cont)
                begin
                    // Open sequence cut short: blank it.
                    pre_n = CNT_W'(pos_reg);
                    pos_p = '0;
                    len_p = 3'd1;
                end
            end
            else if (cont)
            begin
                // Stray continuation after a complete sequence: blank both.
                pre_n = CNT_W'(pos_reg) + CNT_W'(1);
                pos_p = '0;
                done  = 1'b1;
            end
            else
            begin
                // Complete sequence followed by a new character: pass it.
                pre_n     = CNT_W'(pos_reg);
                pre_blank = 1'b0;
                pos_p     = '0;
            end
        end

        // Classification of the new byte.
        mid_n    = 1'b0;
        mid_byte = BLANK;
        pos_m    = pos_p;
        len_m    = len_p;
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            held_next[i] = held_reg[i];
        end
        if (!done)
        begin
            if (b < 8'd128)
            begin
                mid_n    = 1'b1;
                mid_byte = b;
                len_m    = 3'd1;
                pos_m    = '0;
            end
            else if (b inside {[8'hF0:8'hF7]})
            begin
                held_next[0] = b;
                pos_m        = 3'd1;
                len_m        = 3'd4;
            end
            else if (b inside {[8'hE0:8'hEF]})
            begin
                held_next[0] = b;
                pos_m        = 3'd1;
                len_m        = 3'd3;
            end
            else if (b inside {[8'hC0:8'hDF]})
            begin
                held_next[0] = b;
                pos_m        = 3'd1;
                len_m        = 3'd2;
            end
            else if (cont)
            begin
                if (len_p > 3'd1)
                begin
                    held_next[pos_p[1:0]] = b;
                    pos_m = pos_p + 3'd1;
                    if (pos_m >= len_p)
                    begin
                        len_m = 3'd1;
                    end
                end
                else
                begin
                    mid_n = 1'b1;
                    pos_m = '0;
                end
            end
            else
            begin
                mid_n = 1'b1;
                len_m = 3'd1;
                pos_m = '0;
            end
        end

        // End of buffer flushes whatever is still held.
        post_n     = '0;
        post_blank = (len_m > 3'd1);
        pos_next   = pos_m;
        len_next   = len_m;
        if (end_of_buffer)
        begin
            post_n   = CNT_W'(pos_m);
            pos_next = '0;
            len_next = 3'd1;
        end

        // Lay the results out in order: earlier held bytes, new byte, flush.
        pre_mid_n = pre_n + CNT_W'(mid_n);
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (CNT_W'(k) < pre_n)
            begin
                if (pre_blank || (CNT_W'(k) >= CNT_W'(pos_reg)) || (k >= HOLD_DEPTH))
                begin
                    result.bytes[k] = BLANK;
                end
                else
                begin
                    result.bytes[k] = held_reg[2'(k)];
                end
            end
            else if (CNT_W'(k) < pre_mid_n)
            begin
                result.bytes[k] = mid_byte;
            end
            else if (post_blank || (k >= HOLD_DEPTH))
            begin
                result.bytes[k] = BLANK;
            end
            else
            begin
                result.bytes[k] = held_next[2'(k)];
            end
        end
        result.count = pre_mid_n + post_n;
        result.eob   = end_of_buffer;
    end

    // Sequence position and length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= 3'd1;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    // Held sequence bytes; only entries below the position are ever read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

endmodule

[sv/u8s_emit.sv]
// Result buffer: holds the bytes released by one input transfer and
// hands them out one per cycle while out_stall is low. Depends on u8s_pkg.
`timescale 1ns / 1ps

module u8s_emit
    import u8s_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  step_result_t result,
    output logic         ready,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   clean_byte,
    output logic         run_last,
    output logic         buffer_last
);

    logic [MAX_RESULTS-1:0][7:0] buf_reg;
    cnt_t                        cnt_reg;
    cnt_t                        rd_reg;
    logic                        eob_reg;
    logic                        take;

    assign out_valid   = (cnt_reg != '0);
    assign take        = out_valid && !out_stall;
    assign clean_byte  = buf_reg[rd_reg];
    assign run_last    = (cnt_reg == CNT_W'(1));
    assign buffer_last = eob_reg && run_last;

    // A new input transfer is taken once the last waiting result leaves.
    assign ready = (cnt_reg == '0) || (run_last && !out_stall);

    // Count and read pointer of the waiting results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
            eob_reg <= 1'b0;
        end
        else if (load && (result.count != '0))
        begin
            cnt_reg <= result.count;
            rd_reg  <= '0;
            eob_reg <= result.eob;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (!run_last)
            begin
                rd_reg <= rd_reg + CNT_W'(1);
            end
        end
    end

    // Result bytes.
    always_ff @(posedge clk)
    begin
        if (load && (result.count != '0))
        begin
            buf_reg <= result.bytes;
        end
    end

endmodule

[sv/utf8_stream_sanitizer.sv]
// Top level of the UTF-8 stream sanitizer: step logic and result buffer.
// Depends on u8s_pkg, u8s_step and u8s_emit.
`timescale 1ns / 1ps

// One raw byte is taken per transfer and its results appear on the output
// channel from the next cycle, one byte per cycle while out_stall is low, in
// buffer order. A byte releases between zero and five results, because bytes
// of a multi-byte sequence are held back until the following byte or the end
// of the buffer settles them; over a buffer exactly as many bytes leave as
// enter. The input accepts a byte in every cycle in which at most one result
// is still waiting and that one is being taken, so a byte that releases
// several results keeps the input stalled while the result buffer drains.
// run_last marks the last result of each input byte, and buffer_last marks
// the final byte of the buffer, after which the sequence state starts over.

module utf8_stream_sanitizer
    import u8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] clean_byte,
    output logic       run_last,
    output logic       buffer_last
);

    step_result_t step_res;
    logic         ready;
    logic         accept;

    assign in_stall = !ready;
    assign accept   = in_valid && ready;

    u8s_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .accept        (accept),
        .result        (step_res)
    );

    u8s_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .result      (step_res),
        .ready       (ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .clean_byte  (clean_byte),
        .run_last    (run_last),
        .buffer_last (buffer_last)
    );

endmodule

[sv/u8s_checker.sv]
// Port-level checks for the UTF-8 stream sanitizer, bound to the top level.
// Depends on utf8_stream_sanitizer's port list only.
`timescale 1ns / 1ps

module u8s_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       end_of_buffer,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] clean_byte,
    input logic       run_last,
    input logic       buffer_last
);

    // A stalled input transfer keeps its byte until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(data_byte)
            && $stable(end_of_buffer)))
        else $error("stalled input changed");

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(clean_byte)
            && $stable(run_last) && $stable(buffer_last)))
        else $error("stalled result changed");

    // The end of the buffer is always the end of a run.
    a_buf_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && buffer_last) |-> run_last)
        else $error("buffer_last without run_last");

    // A run that is not finished goes on in the next cycle.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !run_last) |=> out_valid)
        else $error("run broke off before its last result");

    // The input stalls only while results are waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind utf8_stream_sanitizer u8s_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .clean_byte    (clean_byte),
    .run_last      (run_last),
    .buffer_last   (buffer_last)
);
